// ===== rtl/hclc_pkg.sv =====
// ----------------------------------------------------------------------------
// hclc_pkg
// shared widths, register indexes, datapath operation codes and structs for
// the hue cycling led color block
// ----------------------------------------------------------------------------
package hclc_pkg;

  // hue phase resolution, one full turn is 2**HUE_BITS
  localparam int HUE_BITS = 16;

  // fixed field widths
  localparam int STEP_W = 16;
  localparam int FRAC_W = 9;
  localparam int COL_W  = 8;
  localparam int FRAC_ONE = 256;

  // derived widths
  localparam int ADD_W  = (HUE_BITS > STEP_W) ? HUE_BITS : STEP_W;
  localparam int H6_W   = HUE_BITS + 3;
  localparam int SECT_W = 3;
  localparam int DIFF_W = HUE_BITS + 9;
  localparam int PROD_W = FRAC_W + DIFF_W;

  // apb register file
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_HUE_STEP     = 3'd0;
  localparam logic [IDX_W-1:0] REG_SATURATION   = 3'd1;
  localparam logic [IDX_W-1:0] REG_COLOR_VALUE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_BRIGHTNESS   = 3'd3;
  localparam logic [IDX_W-1:0] REG_CHARGE_RED   = 3'd4;
  localparam logic [IDX_W-1:0] REG_CHARGE_GREEN = 3'd5;
  localparam logic [IDX_W-1:0] REG_CHARGE_BLUE  = 3'd6;

  typedef struct packed {
    logic [STEP_W-1:0] hue_step;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] color_value;
    logic [FRAC_W-1:0] brightness;
    logic [COL_W-1:0]  charge_red;
    logic [COL_W-1:0]  charge_green;
    logic [COL_W-1:0]  charge_blue;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ADVANCE,
    OP_SECTOR,
    OP_FS,
    OP_Q,
    OP_GS,
    OP_T,
    OP_P,
    OP_SELECT,
    OP_CHARGE,
    OP_SCALE,
    OP_OUT
  } op_e;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    op_e        op;
    logic [1:0] ch;
  } dp_cmd_t;

endpackage

// ===== rtl/hclc_regs.sv =====
// ----------------------------------------------------------------------------
// hclc_regs
// apb register file holding the step, hsv fractions, brightness and the
// color shown while charging
// ----------------------------------------------------------------------------
module hclc_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hclc_pkg::ADDR_W-1:0]    paddr,
  input  logic [hclc_pkg::DATA_W-1:0]    pwdata,
  output logic [hclc_pkg::DATA_W-1:0]    prdata,
  output hclc_pkg::cfg_t                 cfg_o
);
  import hclc_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx   = paddr[ADDR_W-1:2];
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_HUE_STEP:     cfg_d.hue_step     = pwdata[STEP_W-1:0];
        REG_SATURATION:   cfg_d.saturation   = pwdata[FRAC_W-1:0];
        REG_COLOR_VALUE:  cfg_d.color_value  = pwdata[FRAC_W-1:0];
        REG_BRIGHTNESS:   cfg_d.brightness   = pwdata[FRAC_W-1:0];
        REG_CHARGE_RED:   cfg_d.charge_red   = pwdata[COL_W-1:0];
        REG_CHARGE_GREEN: cfg_d.charge_green = pwdata[COL_W-1:0];
        REG_CHARGE_BLUE:  cfg_d.charge_blue  = pwdata[COL_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_step     <= STEP_W'(65);
      cfg_q.saturation   <= FRAC_W'(128);
      cfg_q.color_value  <= FRAC_W'(256);
      cfg_q.brightness   <= FRAC_W'(256);
      cfg_q.charge_red   <= COL_W'(255);
      cfg_q.charge_green <= '0;
      cfg_q.charge_blue  <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_HUE_STEP:     prdata = DATA_W'(cfg_q.hue_step);
      REG_SATURATION:   prdata = DATA_W'(cfg_q.saturation);
      REG_COLOR_VALUE:  prdata = DATA_W'(cfg_q.color_value);
      REG_BRIGHTNESS:   prdata = DATA_W'(cfg_q.brightness);
      REG_CHARGE_RED:   prdata = DATA_W'(cfg_q.charge_red);
      REG_CHARGE_GREEN: prdata = DATA_W'(cfg_q.charge_green);
      REG_CHARGE_BLUE:  prdata = DATA_W'(cfg_q.charge_blue);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hclc_dp.sv =====
// ----------------------------------------------------------------------------
// hclc_dp
// datapath: hue phase, one shared multiplier, hsv intermediates, color and
// output registers
// ----------------------------------------------------------------------------
module hclc_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hclc_pkg::cfg_t             cfg_i,
  input  hclc_pkg::dp_cmd_t          cmd_i,
  output logic [3*hclc_pkg::COL_W-1:0] out_data_o
);
  import hclc_pkg::*;

  localparam logic [DIFF_W-1:0] FULL = DIFF_W'(1) << (HUE_BITS + 8);
  localparam logic [DIFF_W-1:0] TURN = DIFF_W'(1) << HUE_BITS;

  function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] x);
    clamp_frac = (x > FRAC_W'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE) : x;
  endfunction

  // c * 255 / 256 for c up to 256
  function automatic logic [COL_W-1:0] to_byte(input logic [FRAC_W-1:0] c);
    logic [16:0] wide;
    wide    = {c, 8'd0} - 17'(c);
    to_byte = wide[15:8];
  endfunction

  logic [HUE_BITS-1:0] phase_q, phase_d;
  logic [SECT_W-1:0]   sector_q, sector_d;
  logic [HUE_BITS-1:0] f_q, f_d;
  logic [DIFF_W-1:0]   diff_q, diff_d;
  logic [FRAC_W-1:0]   p_q, p_d, q_q, q_d, t_q, t_d;
  logic [COL_W-1:0]    col_q [3];
  logic [COL_W-1:0]    col_d [3];
  logic [3*COL_W-1:0]  out_q, out_d;

  logic [FRAC_W-1:0]   s_cl, v_cl, b_cl;
  logic [ADD_W-1:0]    sum;
  logic [H6_W-1:0]     h6;
  logic [FRAC_W-1:0]   mul_a;
  logic [DIFF_W-1:0]   mul_b;
  logic [PROD_W-1:0]   prod;
  logic [FRAC_W-1:0]   cr, cg, cb;

  assign s_cl = clamp_frac(cfg_i.saturation);
  assign v_cl = clamp_frac(cfg_i.color_value);
  assign b_cl = clamp_frac(cfg_i.brightness);

  assign sum = ADD_W'(phase_q) + ADD_W'(cfg_i.hue_step);
  assign h6  = {phase_q, 2'b00} + {1'b0, phase_q, 1'b0};

  // shared multiplier operand selection
  always_comb begin
    mul_a = v_cl;
    mul_b = diff_q;
    case (cmd_i.op)
      OP_FS:    begin mul_a = s_cl; mul_b = DIFF_W'(f_q); end
      OP_GS:    begin mul_a = s_cl; mul_b = TURN - DIFF_W'(f_q); end
      OP_P:     begin mul_a = v_cl; mul_b = DIFF_W'(FRAC_W'(FRAC_ONE) - s_cl); end
      OP_SCALE: begin mul_a = b_cl; mul_b = DIFF_W'(col_q[cmd_i.ch]); end
      default:  begin mul_a = v_cl; mul_b = diff_q; end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // sector to component mapping
  always_comb begin
    case (sector_q)
      3'd1:    begin cr = q_q;  cg = v_cl; cb = p_q;  end
      3'd2:    begin cr = p_q;  cg = v_cl; cb = t_q;  end
      3'd3:    begin cr = p_q;  cg = q_q;  cb = v_cl; end
      3'd4:    begin cr = t_q;  cg = p_q;  cb = v_cl; end
      3'd5:    begin cr = v_cl; cg = p_q;  cb = q_q;  end
      default: begin cr = v_cl; cg = t_q;  cb = p_q;  end
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    sector_d = sector_q;
    f_d      = f_q;
    diff_d   = diff_q;
    p_d      = p_q;
    q_d      = q_q;
    t_d      = t_q;
    col_d    = col_q;
    out_d    = out_q;
    case (cmd_i.op)
      OP_ADVANCE: phase_d = sum[HUE_BITS-1:0];
      OP_SECTOR: begin
        sector_d = h6[H6_W-1:HUE_BITS];
        f_d      = h6[HUE_BITS-1:0];
      end
      OP_FS, OP_GS: diff_d = FULL - prod[DIFF_W-1:0];
      OP_Q:      q_d = prod[HUE_BITS+8 +: FRAC_W];
      OP_T:      t_d = prod[HUE_BITS+8 +: FRAC_W];
      OP_P:      p_d = prod[8 +: FRAC_W];
      OP_SELECT: begin
        col_d[CH_RED]   = to_byte(cr);
        col_d[CH_GREEN] = to_byte(cg);
        col_d[CH_BLUE]  = to_byte(cb);
      end
      OP_CHARGE: begin
        col_d[CH_RED]   = cfg_i.charge_red;
        col_d[CH_GREEN] = cfg_i.charge_green;
        col_d[CH_BLUE]  = cfg_i.charge_blue;
      end
      OP_SCALE:  col_d[cmd_i.ch] = prod[8 +: COL_W];
      OP_OUT:    out_d = {col_q[CH_BLUE], col_q[CH_GREEN], col_q[CH_RED]};
      default:   phase_d = phase_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    f_q      <= f_d;
    diff_q   <= diff_d;
    p_q      <= p_d;
    q_q      <= q_d;
    t_q      <= t_d;
    col_q    <= col_d;
    out_q    <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/hclc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hclc_ctrl
// controller: accepts an item, steps the datapath through the hsv sequence
// or the charging path, and owns the output valid
// ----------------------------------------------------------------------------
module hclc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_charging_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hclc_pkg::dp_cmd_t   cmd_o
);
  import hclc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_SECTOR,
    ST_FS,
    ST_Q,
    ST_GS,
    ST_T,
    ST_P,
    ST_SELECT,
    ST_CHARGE,
    ST_SCALE_R,
    ST_SCALE_G,
    ST_SCALE_B,
    ST_DELIVER
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.op = OP_IDLE;
    cmd_o.ch = CH_RED;
    case (state_q)
      ST_ADVANCE: cmd_o.op = OP_ADVANCE;
      ST_SECTOR:  cmd_o.op = OP_SECTOR;
      ST_FS:      cmd_o.op = OP_FS;
      ST_Q:       cmd_o.op = OP_Q;
      ST_GS:      cmd_o.op = OP_GS;
      ST_T:       cmd_o.op = OP_T;
      ST_P:       cmd_o.op = OP_P;
      ST_SELECT:  cmd_o.op = OP_SELECT;
      ST_CHARGE:  cmd_o.op = OP_CHARGE;
      ST_SCALE_R: begin cmd_o.op = OP_SCALE; cmd_o.ch = CH_RED;   end
      ST_SCALE_G: begin cmd_o.op = OP_SCALE; cmd_o.ch = CH_GREEN; end
      ST_SCALE_B: begin cmd_o.op = OP_SCALE; cmd_o.ch = CH_BLUE;  end
      ST_DELIVER: cmd_o.op = out_free ? OP_OUT : OP_IDLE;
      default:    cmd_o.op = OP_IDLE;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_charging_i ? ST_CHARGE : ST_ADVANCE;
        end
      end
      ST_ADVANCE: state_d = ST_SECTOR;
      ST_SECTOR:  state_d = ST_FS;
      ST_FS:      state_d = ST_Q;
      ST_Q:       state_d = ST_GS;
      ST_GS:      state_d = ST_T;
      ST_T:       state_d = ST_P;
      ST_P:       state_d = ST_SELECT;
      ST_SELECT:  state_d = ST_SCALE_R;
      ST_CHARGE:  state_d = ST_SCALE_R;
      ST_SCALE_R: state_d = ST_SCALE_G;
      ST_SCALE_G: state_d = ST_SCALE_B;
      ST_SCALE_B: state_d = ST_DELIVER;
      ST_DELIVER: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/hue_cycle_led_color_top.sv =====
// ----------------------------------------------------------------------------
// hue_cycle_led_color_top
// hue cycling led color generator with apb configuration and stream ports
// ----------------------------------------------------------------------------
// Each input item is one update tick carrying a charging flag. While charging
// the block outputs the configured charge color and the hue phase holds;
// otherwise the hue phase advances by hue_step (wrapping over one turn) and
// is turned into rgb by six-sector hsv with the configured saturation and
// value, each component mapped to 0..255. Every color, the charge color too,
// is then scaled by brightness over 256, truncating at each step. Fractions
// above 256 act as 256. One multiplier is shared by every product, so a
// running tick steps through the hsv states, a charging tick through the
// charge state, then both scale each channel; the next item is taken once
// the result has moved into the output register, which may still be waiting
// on the downstream side. Registers sit at byte address 4*index: hue_step,
// saturation, color_value, brightness, charge_red, charge_green, charge_blue.
// ----------------------------------------------------------------------------
module hue_cycle_led_color_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hclc_pkg::ADDR_W-1:0]   paddr,
  input  logic [hclc_pkg::DATA_W-1:0]   pwdata,
  output logic [hclc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [0] charging, rest zero
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata   // [7:0] red, [15:8] green, [23:16] blue
);
  import hclc_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  assign pready = 1'b1;

  hclc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // sequencer for the hsv steps and the output handshake
  hclc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_charging_i (s_axis_tdata[0]),
    .in_ready_o    (s_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .cmd_o         (cmd)
  );

  // phase, shared multiplier and color registers
  hclc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .out_data_o (m_axis_tdata)
  );

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for hue_cycle_led_color_top: a queue-fed stream driver
// sends charging/running ticks with random gaps while the downstream side
// stalls at random; a monitor predicts every led color from its own copy of
// the registers and the hue phase and checks each result item in order
// ----------------------------------------------------------------------------
module tb;
  import hclc_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 3;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 5000; // cycles without any handshake
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_TICKS  = 60;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0] pwdata        = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = '0;  // [0] charging, rest zero
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [23:0]       m_axis_tdata;        // [7:0] red, [15:8] green, [23:16] blue

  hue_cycle_led_color_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // predictor copy of the register file and the hue phase
  cfg_t                cfg_m;
  logic [HUE_BITS-1:0] hue_phase_m;

  logic [7:0]  tick_q [$];   // ticks waiting to be sent
  logic [23:0] rgb_q  [$];   // predicted colors waiting for their result item
  int          errors    = 0;
  int          watchdog  = 0;
  int          in_gap    = 0;
  int          out_stall = 0;
  bit          no_idle   = 1'b0;
  logic        tick_taken = 1'b0;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // fractions above one act as one
  function automatic longint unsigned frac_clamp(input logic [FRAC_W-1:0] x);
    return (x > FRAC_ONE) ? FRAC_ONE : longint'(x);
  endfunction

  // color for one tick; a running tick advances the hue phase
  function automatic logic [23:0] next_led_color(input logic charging);
    longint unsigned one, s, v, bri, h6, f, p, q, t;
    longint unsigned comp [3];
    logic [2:0] sector;
    logic [23:0] rgb;
    int i;
    if (charging) begin
      comp[0] = cfg_m.charge_red;
      comp[1] = cfg_m.charge_green;
      comp[2] = cfg_m.charge_blue;
    end else begin
      one = 64'd1 << HUE_BITS;
      s   = frac_clamp(cfg_m.saturation);
      v   = frac_clamp(cfg_m.color_value);
      hue_phase_m = HUE_BITS'(hue_phase_m + cfg_m.hue_step);
      h6     = 64'(hue_phase_m) * 6;
      sector = 3'(h6 >> HUE_BITS);
      f      = h6 & (one - 1);
      p = (v * (256 - s)) >> 8;
      q = (v * (256 * one - f * s)) >> (HUE_BITS + 8);
      t = (v * (256 * one - (one - f) * s)) >> (HUE_BITS + 8);
      // six hsv sectors
      case (sector)
        3'd1: begin comp[0] = q; comp[1] = v; comp[2] = p; end
        3'd2: begin comp[0] = p; comp[1] = v; comp[2] = t; end
        3'd3: begin comp[0] = p; comp[1] = q; comp[2] = v; end
        3'd4: begin comp[0] = t; comp[1] = p; comp[2] = v; end
        3'd5: begin comp[0] = v; comp[1] = p; comp[2] = q; end
        default: begin comp[0] = v; comp[1] = t; comp[2] = p; end
      endcase
      for (i = 0; i < 3; i++) comp[i] = (comp[i] * 255) >> 8;
    end
    bri = frac_clamp(cfg_m.brightness);
    for (i = 0; i < 3; i++) rgb[8*i +: 8] = 8'((comp[i] * bri) >> 8);
    return rgb;
  endfunction

  // stream driver and downstream ready, changed on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || tick_taken) begin
        if (in_gap > 0) begin
          s_axis_tvalid <= 1'b0;
          in_gap = in_gap - 1;
        end else if (tick_q.size() > 0) begin
          s_axis_tdata  <= tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        m_axis_tready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 99) < 30) out_stall = pick_gap();
      end
    end
  end

  // monitor: register mirror, prediction, result check and watchdog
  always @(posedge clk_i) begin
    logic [23:0] want;
    logic        busy;
    int          c;
    if (!rst_ni) begin
      cfg_m = '{hue_step: 16'd65, saturation: 9'd128, color_value: 9'd256,
                brightness: 9'd256, charge_red: 8'd255, charge_green: 8'd0,
                charge_blue: 8'd0};
      hue_phase_m = '0;
      tick_taken <= 1'b0;
    end else begin
      busy = 1'b0;
      tick_taken <= s_axis_tvalid && s_axis_tready;
      if (psel && penable && pwrite && pready) begin
        busy = 1'b1;
        case (paddr[ADDR_W-1:2])
          REG_HUE_STEP:     cfg_m.hue_step     = pwdata[STEP_W-1:0];
          REG_SATURATION:   cfg_m.saturation   = pwdata[FRAC_W-1:0];
          REG_COLOR_VALUE:  cfg_m.color_value  = pwdata[FRAC_W-1:0];
          REG_BRIGHTNESS:   cfg_m.brightness   = pwdata[FRAC_W-1:0];
          REG_CHARGE_RED:   cfg_m.charge_red   = pwdata[COL_W-1:0];
          REG_CHARGE_GREEN: cfg_m.charge_green = pwdata[COL_W-1:0];
          REG_CHARGE_BLUE:  cfg_m.charge_blue  = pwdata[COL_W-1:0];
          default: ;  // unknown index is ignored
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        busy = 1'b1;
        rgb_q.push_back(next_led_color(s_axis_tdata[0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        busy = 1'b1;
        if (rgb_q.size() == 0) begin
          $display("%0t unexpected result item: expected none, got %06h",
                   $time, m_axis_tdata);
          errors++;
        end else begin
          want = rgb_q.pop_front();
          for (c = 0; c < 3; c++) begin
            if (want[8*c +: 8] !== m_axis_tdata[8*c +: 8]) begin
              $display("%0t %s: expected %0d, got %0d", $time,
                       (c == 0) ? "red" : (c == 1) ? "green" : "blue",
                       want[8*c +: 8], m_axis_tdata[8*c +: 8]);
              errors++;
            end
          end
        end
      end
      watchdog = busy ? 0 : watchdog + 1;
      if (watchdog >= STALL_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("hue_cycle_led_color_top: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // field value with random bits above the field width
  task automatic write_field(input logic [IDX_W-1:0] idx, input int unsigned value,
                             input int width);
    logic [DATA_W-1:0] word;
    word = $urandom;
    word = ((word >> width) << width) | value;
    write_reg(idx, word);
  endtask

  function automatic int unsigned rand_frac();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return FRAC_ONE;
    if (r == 2) return 511;
    if (r == 3) return $urandom_range(257, 511);
    return $urandom_range(0, FRAC_ONE);
  endfunction

  function automatic int unsigned rand_color();
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic int unsigned rand_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r < 5) return $urandom_range(1, 2000);
    return $urandom_range(0, 65535);
  endfunction

  task automatic push_ticks(input int n, input int charge_pct);
    int i;
    for (i = 0; i < n; i++) tick_q.push_back({7'd0, ($urandom_range(0, 99) < charge_pct)});
  endtask

  // everything sent, every result back, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || rgb_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int ph;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings: charging color, then a few running ticks
    tick_q = '{8'd1, 8'd0, 8'd0, 8'd0};
    wait_idle();

    // largest step, full saturation and value: phase wraps on the first tick
    write_field(REG_HUE_STEP, 65535, STEP_W);
    write_field(REG_SATURATION, 256, FRAC_W);
    write_field(REG_COLOR_VALUE, 256, FRAC_W);
    write_field(REG_BRIGHTNESS, 256, FRAC_W);
    tick_q = '{8'd0, 8'd0, 8'd0};
    wait_idle();

    // about a sixth of a turn per tick walks through every sector,
    // fractions above one clamp
    write_field(REG_HUE_STEP, 10923, STEP_W);
    write_field(REG_SATURATION, 511, FRAC_W);
    write_field(REG_COLOR_VALUE, 511, FRAC_W);
    write_field(REG_BRIGHTNESS, 511, FRAC_W);
    write_field(REG_CHARGE_RED, 0, COL_W);
    write_field(REG_CHARGE_GREEN, 255, COL_W);
    write_field(REG_CHARGE_BLUE, 128, COL_W);
    tick_q = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
    wait_idle();

    // zero everything, white charge color scaled down to nothing
    write_field(REG_HUE_STEP, 0, STEP_W);
    write_field(REG_SATURATION, 0, FRAC_W);
    write_field(REG_COLOR_VALUE, 0, FRAC_W);
    write_field(REG_BRIGHTNESS, 0, FRAC_W);
    write_field(REG_CHARGE_RED, 255, COL_W);
    write_field(REG_CHARGE_GREEN, 255, COL_W);
    write_field(REG_CHARGE_BLUE, 255, COL_W);
    tick_q = '{8'd0, 8'd1};
    wait_idle();

    // write to an unknown index must change nothing
    write_field(REG_UNUSED, $urandom, 0);
    write_field(REG_BRIGHTNESS, 200, FRAC_W);
    write_field(REG_COLOR_VALUE, 180, FRAC_W);
    tick_q = '{8'd0, 8'd1};
    wait_idle();

    // random settings, every third phase with no idling on either side
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_field(REG_HUE_STEP, rand_step(), STEP_W);
      write_field(REG_SATURATION, rand_frac(), FRAC_W);
      write_field(REG_COLOR_VALUE, rand_frac(), FRAC_W);
      write_field(REG_BRIGHTNESS, rand_frac(), FRAC_W);
      write_field(REG_CHARGE_RED, rand_color(), COL_W);
      write_field(REG_CHARGE_GREEN, rand_color(), COL_W);
      write_field(REG_CHARGE_BLUE, rand_color(), COL_W);
      if ($urandom_range(0, 3) == 0) write_field(REG_UNUSED, $urandom, 0);
      no_idle = (ph % 3 == 2);
      push_ticks(PHASE_TICKS, $urandom_range(5, 50));
      wait_idle();
    end

    if (errors == 0) begin
      $display("hue_cycle_led_color_top: match");
    end else begin
      $display("hue_cycle_led_color_top: mismatch");
    end
    $finish;
  end

endmodule
